/* hdl/pulg_pkg.sv */
// ----------------------------------------------------------------------------
// PIN unlock line gate package
// Shared constants, types and a helper function for the PIN line gate.
// ----------------------------------------------------------------------------
package pulg_pkg;

    // Longest line kept while locked, and the PIN length ceiling.
    localparam int LINE_BYTES    = 32;
    localparam int PIN_MAX_BYTES = 16;

    // The PIN registers hold sixteen characters, eight to a 64-bit register.
    localparam int PIN_SLOTS     = 16;
    localparam int PIN_IDX_W     = $clog2(PIN_SLOTS);
    localparam int PIN_LEN_W     = $clog2(PIN_SLOTS + 1);

    // Length of the text "unlock " in front of the PIN.
    localparam int PREFIX_LEN    = 7;
    localparam int PREFIX_IDX_W  = $clog2(PREFIX_LEN);

    // Line and string counters must hold LINE_BYTES itself.
    localparam int LINE_CNT_W    = $clog2(LINE_BYTES + 1);

    // Configuration port geometry.
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIN_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIN_BYTES_LO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIN_BYTES_HI = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FAILURES = 2'd3;

    // Line terminators.
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    // Input word kinds.
    localparam logic KIND_BYTE        = 1'b0;
    localparam logic KIND_SESSION_END = 1'b1;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_FORWARD    = 3'd1,
        EV_UNLOCKED   = 3'd2,
        EV_PROMPT     = 3'd3,
        EV_DISCONNECT = 3'd4
    } event_t;

    // Configuration as seen by the line logic.
    typedef struct packed {
        logic [PIN_SLOTS-1:0][7:0] pin_chars;
        logic [PIN_LEN_W-1:0]      eff_len;
        logic [7:0]                max_failures;
    } pulg_cfg_t;

    // One result word.
    typedef struct packed {
        event_t     ev;
        logic [7:0] fwd;
        logic       unlocked;
    } pulg_result_t;

    // Characters of the fixed prefix "unlock ".
    function automatic logic [7:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h75; // u
            3'd1:    ch = 8'h6E; // n
            3'd2:    ch = 8'h6C; // l
            3'd3:    ch = 8'h6F; // o
            3'd4:    ch = 8'h63; // c
            3'd5:    ch = 8'h6B; // k
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

endpackage

/* hdl/pulg_cfg.sv */
// ----------------------------------------------------------------------------
// PIN unlock configuration registers
// Holds the four configuration registers and derives the effective PIN length.
// ----------------------------------------------------------------------------
module pulg_cfg
    import pulg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output pulg_cfg_t              cfg
);

    logic [4:0]            pin_length_reg;
    logic [63:0]           pin_lo_reg;
    logic [63:0]           pin_hi_reg;
    logic [7:0]            max_failures_reg;
    logic [PIN_LEN_W-1:0]  clamp_len;
    logic [PIN_LEN_W-1:0]  eff_len;
    logic [PIN_SLOTS-1:0][7:0] chars;

    // Register writes, decoded by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_length_reg   <= 5'd4;
            pin_lo_reg       <= '0;
            pin_hi_reg       <= '0;
            max_failures_reg <= 8'd3;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PIN_LENGTH:   pin_length_reg   <= cfg_data[4:0];
                CFG_PIN_BYTES_LO: pin_lo_reg       <= cfg_data;
                CFG_PIN_BYTES_HI: pin_hi_reg       <= cfg_data;
                CFG_MAX_FAILURES: max_failures_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign chars = {pin_hi_reg, pin_lo_reg};

    // The PIN ends at the first zero character within its clamped length.
    always_comb
    begin
        if (pin_length_reg > 5'(PIN_MAX_BYTES))
        begin
            clamp_len = PIN_LEN_W'(PIN_MAX_BYTES);
        end
        else
        begin
            clamp_len = PIN_LEN_W'(pin_length_reg);
        end
        eff_len = clamp_len;
        for (int i = PIN_SLOTS - 1; i >= 0; i--)
        begin
            if ((PIN_LEN_W'(i) < clamp_len) && (chars[i] == BYTE_NUL))
            begin
                eff_len = PIN_LEN_W'(i);
            end
        end
    end

    assign cfg.pin_chars    = chars;
    assign cfg.eff_len      = eff_len;
    assign cfg.max_failures = max_failures_reg;

endmodule

/* hdl/pulg_core.sv */
// ----------------------------------------------------------------------------
// PIN unlock line matcher
// Holds the gate, line and failure state and works out one result per word.
// ----------------------------------------------------------------------------
module pulg_core
    import pulg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  logic         item_kind,
    input  logic [7:0]   item_byte,
    input  pulg_cfg_t    cfg,
    output pulg_result_t result
);

    logic                  gate_open_reg,       gate_open_next;
    logic [LINE_CNT_W-1:0] line_count_reg,      line_count_next;
    logic                  line_overflowed_reg, line_overflowed_next;
    logic                  still_matching_reg,  still_matching_next;
    logic                  string_ended_reg,    string_ended_next;
    logic [LINE_CNT_W-1:0] string_length_reg,   string_length_next;
    logic [7:0]            failure_count_reg,   failure_count_next;

    logic [LINE_CNT_W-1:0] exp_len;
    logic [LINE_CNT_W-1:0] pin_off;
    logic [7:0]            want;
    logic [7:0]            fail_inc;
    logic                  is_eol;
    logic                  match;
    event_t                ev;
    logic [7:0]            fwd;

    // Expected character at the current string position.
    assign exp_len = LINE_CNT_W'(PREFIX_LEN) + LINE_CNT_W'(cfg.eff_len);
    assign pin_off = string_length_reg - LINE_CNT_W'(PREFIX_LEN);

    always_comb
    begin
        if (string_length_reg < LINE_CNT_W'(PREFIX_LEN))
        begin
            want = prefix_char(string_length_reg[PREFIX_IDX_W-1:0]);
        end
        else
        begin
            want = cfg.pin_chars[pin_off[PIN_IDX_W-1:0]];
        end
    end

    assign is_eol   = (item_byte == BYTE_CR) || (item_byte == BYTE_LF);
    assign match    = !line_overflowed_reg && still_matching_reg
                      && (string_length_reg == exp_len);
    assign fail_inc = (failure_count_reg == 8'hFF) ? failure_count_reg
                                                   : failure_count_reg + 8'd1;

    // Next state and result for the word in hand.
    always_comb
    begin
        gate_open_next       = gate_open_reg;
        line_count_next      = line_count_reg;
        line_overflowed_next = line_overflowed_reg;
        still_matching_next  = still_matching_reg;
        string_ended_next    = string_ended_reg;
        string_length_next   = string_length_reg;
        failure_count_next   = failure_count_reg;
        ev                   = EV_NONE;
        fwd                  = 8'd0;

        if (item_kind == KIND_SESSION_END)
        begin
            // Session end relocks and clears everything.
            gate_open_next       = 1'b0;
            failure_count_next   = 8'd0;
            line_count_next      = '0;
            line_overflowed_next = 1'b0;
            still_matching_next  = 1'b1;
            string_ended_next    = 1'b0;
            string_length_next   = '0;
        end
        else if (gate_open_reg)
        begin
            ev  = EV_FORWARD;
            fwd = item_byte;
        end
        else if (is_eol)
        begin
            // An empty line without overflow is ignored.
            if ((line_count_reg != '0) || line_overflowed_reg)
            begin
                line_count_next      = '0;
                line_overflowed_next = 1'b0;
                still_matching_next  = 1'b1;
                string_ended_next    = 1'b0;
                string_length_next   = '0;
                if (match)
                begin
                    gate_open_next     = 1'b1;
                    failure_count_next = 8'd0;
                    ev                 = EV_UNLOCKED;
                end
                else
                begin
                    failure_count_next = fail_inc;
                    ev = (fail_inc >= cfg.max_failures) ? EV_DISCONNECT : EV_PROMPT;
                end
            end
        end
        else if (line_count_reg >= LINE_CNT_W'(LINE_BYTES))
        begin
            line_overflowed_next = 1'b1;
        end
        else
        begin
            line_count_next = line_count_reg + LINE_CNT_W'(1);
            if (!string_ended_reg)
            begin
                if (item_byte == BYTE_NUL)
                begin
                    string_ended_next = 1'b1;
                end
                else
                begin
                    if (!(string_length_reg < exp_len) || (item_byte != want))
                    begin
                        still_matching_next = 1'b0;
                    end
                    string_length_next = string_length_reg + LINE_CNT_W'(1);
                end
            end
        end
    end

    // State registers advance once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_open_reg       <= 1'b0;
            line_count_reg      <= '0;
            line_overflowed_reg <= 1'b0;
            still_matching_reg  <= 1'b1;
            string_ended_reg    <= 1'b0;
            string_length_reg   <= '0;
            failure_count_reg   <= 8'd0;
        end
        else if (step_en)
        begin
            gate_open_reg       <= gate_open_next;
            line_count_reg      <= line_count_next;
            line_overflowed_reg <= line_overflowed_next;
            still_matching_reg  <= still_matching_next;
            string_ended_reg    <= string_ended_next;
            string_length_reg   <= string_length_next;
            failure_count_reg   <= failure_count_next;
        end
    end

    assign result.ev       = ev;
    assign result.fwd      = fwd;
    assign result.unlocked = gate_open_next;

endmodule

/* hdl/pin_unlock_line_gate.sv */
// An accepted word waits in the input register until the result register is
// free or draining. Throughput: one word per cycle while out_ready is high; the
// input register takes a new word while the previous result waits on output.
// Reset: asynchronous, active low; the gate comes up locked with all line and
// failure state cleared and the configuration at its reset values.
// ----------------------------------------------------------------------------
// PIN unlock line gate
// Console byte gate that stays locked until a matching PIN line is received.
// ----------------------------------------------------------------------------
module pin_unlock_line_gate
    import pulg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             event_res,
    output logic [7:0]             forward_byte,
    output logic                   is_unlocked
);

    pulg_cfg_t    cfg;
    pulg_result_t result;

    logic       in_valid_reg, in_valid_next;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] event_reg;
    logic [7:0] fwd_reg;
    logic       unlocked_reg;
    logic       in_accept;
    logic       step;

    pulg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A held word is processed when the result register is free or draining.
    assign step      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step;
    assign in_accept = in_valid && in_ready;

    pulg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step),
        .item_kind (kind_reg),
        .item_byte (byte_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Valid flags of the input and result registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
        if (step)
        begin
            event_reg    <= result.ev;
            fwd_reg      <= result.fwd;
            unlocked_reg <= result.unlocked;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign forward_byte = fwd_reg;
    assign is_unlocked  = unlocked_reg;

endmodule

/* hdl/pulg_checker.sv */
// ----------------------------------------------------------------------------
// PIN unlock gate checker
// Port-level assertions on the result words of the PIN line gate.
// ----------------------------------------------------------------------------
module pulg_checker
    import pulg_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [2:0]             event_res,
    input logic [7:0]             forward_byte,
    input logic                   is_unlocked
);

    // A stalled result word holds steady.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(forward_byte) && $stable(is_unlocked))
        else $error("stalled result word changed");

    // Only forwarded words carry a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_FORWARD) |-> forward_byte == 8'd0)
        else $error("byte present on a word that is not forwarded");

    // Forwarding and unlocking leave the gate open.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_res == EV_FORWARD) || (event_res == EV_UNLOCKED))
            |-> is_unlocked)
        else $error("gate shown locked on forward or unlock");

    // Prompts and disconnect requests only come while locked.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_res == EV_PROMPT) || (event_res == EV_DISCONNECT))
            |-> !is_unlocked)
        else $error("gate shown open on a failed line");

endmodule

bind pin_unlock_line_gate pulg_checker u_pulg_checker (.*);
